@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the cipher modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and helper functions of the Playfair digraph cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int Side  = 5;
   localparam int Cells = 25;

   localparam logic [6:0] AsciiA = 7'd65;
   localparam logic [6:0] AsciiZ = 7'd90;
   localparam logic [4:0] IdxX   = 5'd23;
   localparam logic [4:0] IdxY   = 5'd24;

   // Item opcodes.
   localparam logic [1:0] OpKeyLetter  = 2'd0;
   localparam logic [1:0] OpKeyDone    = 2'd1;
   localparam logic [1:0] OpTextLetter = 2'd2;
   localparam logic [1:0] OpEndOfText  = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] letter;
   } pfc_req_type;

   typedef struct packed {
      logic [6:0] cipher_letter;
      logic       last_of_pair;
   } pfc_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic fill_step;
      logic cell_rd_b;
      logic ca_load;
      logic cb_load;
      logic sq_rd_b;
      logic l1_load;
      logic l2_load;
      logic out_second;
   } pfc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit_start;
      logic fill_start;
      logic fill_last;
   } pfc_stat_type;

   typedef struct packed {
      logic [4:0] t1;
      logic [4:0] t2;
   } pfc_cells_type;

   // Row of a cell index, by comparison against multiples of the side.
   function automatic logic [2:0] row_of(logic [4:0] c);
      logic [2:0] r;
      if (c >= 5'(4 * Side))      r = 3'd4;
      else if (c >= 5'(3 * Side)) r = 3'd3;
      else if (c >= 5'(2 * Side)) r = 3'd2;
      else if (c >= 5'(Side))     r = 3'd1;
      else                        r = 3'd0;
      return r;
   endfunction

   // Row times the side, as shift and add.
   function automatic logic [4:0] row_base(logic [2:0] r);
      return {r, 2'b00} + {2'b00, r};
   endfunction

   function automatic logic [2:0] col_of(logic [4:0] c);
      logic [4:0] d;
      d = c - row_base(row_of(c));
      return d[2:0];
   endfunction

   // Step one place along a row or column, wrapping at the edge.
   function automatic logic [2:0] step_wrap(logic [2:0] v);
      return (v == 3'(Side - 1)) ? 3'd0 : v + 3'd1;
   endfunction

   function automatic logic [4:0] cell_at(logic [2:0] r, logic [2:0] c);
      return row_base(r) + {2'b00, c};
   endfunction

   // Playfair cell mapping for one digraph.
   function automatic pfc_cells_type encipher_cells(logic [4:0] ca, logic [4:0] cb);
      logic [2:0]    r1, c1, r2, c2;
      pfc_cells_type res;
      r1 = row_of(ca);
      c1 = col_of(ca);
      r2 = row_of(cb);
      c2 = col_of(cb);
      if (r1 == r2) begin
         res.t1 = cell_at(r1, step_wrap(c1));
         res.t2 = cell_at(r2, step_wrap(c2));
      end else if (c1 == c2) begin
         res.t1 = cell_at(step_wrap(r1), c1);
         res.t2 = cell_at(step_wrap(r2), c2);
      end else begin
         res.t1 = cell_at(r1, c2);
         res.t2 = cell_at(r2, c1);
      end
      return res;
   endfunction

   // Filler letter that closes a digraph.
   function automatic logic [4:0] filler_for(logic [4:0] idx);
      return (idx == IdxX) ? IdxY : IdxX;
   endfunction

endpackage

@@ sv/pfc_ram.sv @@
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pfc_datapath.sv @@
// ----------------------------------------------------------------------------
// pfc_datapath
// Item decode, key square storage, digraph state and cipher lookups.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pfc_pkg::pfc_req_type req_data,
   input  pfc_pkg::pfc_cmd_type cmd,
   output pfc_pkg::pfc_stat_type stat,
   output pfc_pkg::pfc_rsp_type rsp_data
);

   logic [24:0] placed_ff, placed_in;
   logic [4:0]  fill_count_ff, fill_count_in;
   logic        key_ready_ff, key_ready_in;
   logic [4:0]  pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [4:0]  fill_idx_ff, fill_idx_in;
   logic [4:0]  a_ff, a_in, b_ff, b_in;
   logic [4:0]  ca_ff, ca_in, cb_ff, cb_in;
   logic [4:0]  l1_ff, l1_in, l2_ff, l2_in;

   logic        letter_ok;
   logic [4:0]  idx;
   logic        room;
   logic        key_wr, fill_wr, wr_en;
   logic [4:0]  wr_letter;
   logic [4:0]  cell_rdata, sq_rdata;
   logic [4:0]  cell_rd_addr, sq_rd_addr;
   logic [4:0]  pair_b;
   logic [4:0]  out_idx;
   pfc_pkg::pfc_cells_type targets;

   // Letter decode: Z folds onto Y.
   always_comb begin
      letter_ok = (req_data.letter >= pfc_pkg::AsciiA) &&
                  (req_data.letter <= pfc_pkg::AsciiZ);
      if (req_data.letter == pfc_pkg::AsciiZ) begin
         idx = pfc_pkg::IdxY;
      end else begin
         idx = 5'(req_data.letter - pfc_pkg::AsciiA);
      end
   end

   // Square writes from key letters and from the key-done fill walk.
   assign room      = fill_count_ff < 5'(pfc_pkg::Cells);
   assign key_wr    = cmd.accept && (req_data.opcode == pfc_pkg::OpKeyLetter) &&
                      !key_ready_ff && letter_ok && !placed_ff[idx] && room;
   assign fill_wr   = cmd.fill_step && !placed_ff[fill_idx_ff] && room;
   assign wr_en     = key_wr || fill_wr;
   assign wr_letter = cmd.fill_step ? fill_idx_ff : idx;

   // Second letter of a digraph closed by a text letter.
   assign pair_b = (idx == pend_ff) ? pfc_pkg::filler_for(pend_ff) : idx;

   // Status for the controller.
   always_comb begin
      stat.fill_start = req_data.opcode == pfc_pkg::OpKeyDone;
      stat.emit_start = key_ready_ff && pend_valid_ff &&
                        (((req_data.opcode == pfc_pkg::OpTextLetter) && letter_ok) ||
                         (req_data.opcode == pfc_pkg::OpEndOfText));
      stat.fill_last  = fill_idx_ff == 5'(pfc_pkg::Cells - 1);
   end

   // Next-state logic of the digraph and key registers.
   always_comb begin
      placed_in     = placed_ff | (wr_en ? (25'(1) << wr_letter) : 25'(0));
      fill_count_in = fill_count_ff + {4'b0, wr_en};
      key_ready_in  = key_ready_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      fill_idx_in   = fill_idx_ff;
      a_in          = a_ff;
      b_in          = b_ff;

      if (cmd.accept) begin
         case (req_data.opcode)
            pfc_pkg::OpKeyDone: begin
               fill_idx_in = 5'd0;
            end
            pfc_pkg::OpTextLetter: begin
               if (key_ready_ff && letter_ok) begin
                  if (!pend_valid_ff) begin
                     pend_in       = idx;
                     pend_valid_in = 1'b1;
                  end else begin
                     a_in = pend_ff;
                     b_in = pair_b;
                     if (idx != pend_ff) begin
                        pend_valid_in = 1'b0;
                     end
                  end
               end
            end
            pfc_pkg::OpEndOfText: begin
               if (key_ready_ff && pend_valid_ff) begin
                  pend_valid_in = 1'b0;
                  a_in          = pend_ff;
                  b_in          = pfc_pkg::filler_for(pend_ff);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.fill_step) begin
         fill_idx_in = fill_idx_ff + 5'd1;
         if (stat.fill_last) begin
            key_ready_in = 1'b1;
         end
      end
   end

   // Lookup capture registers.
   assign targets      = pfc_pkg::encipher_cells(ca_ff, cb_ff);
   assign cell_rd_addr = cmd.cell_rd_b ? b_ff : a_ff;
   assign sq_rd_addr   = cmd.sq_rd_b ? targets.t2 : targets.t1;
   assign ca_in        = cmd.ca_load ? cell_rdata : ca_ff;
   assign cb_in        = cmd.cb_load ? cell_rdata : cb_ff;
   assign l1_in        = cmd.l1_load ? sq_rdata : l1_ff;
   assign l2_in        = cmd.l2_load ? sq_rdata : l2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         placed_ff     <= '0;
         fill_count_ff <= '0;
         key_ready_ff  <= 1'b0;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         fill_idx_ff   <= '0;
      end else begin
         placed_ff     <= placed_in;
         fill_count_ff <= fill_count_in;
         key_ready_ff  <= key_ready_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         fill_idx_ff   <= fill_idx_in;
      end
      a_ff  <= a_in;
      b_ff  <= b_in;
      ca_ff <= ca_in;
      cb_ff <= cb_in;
      l1_ff <= l1_in;
      l2_ff <= l2_in;
   end

   // Square: cell to letter.
   pfc_ram #(
      .Width(5),
      .Depth(pfc_pkg::Cells)
   ) u_square (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_count_ff),
      .wr_data(wr_letter),
      .rd_addr(sq_rd_addr),
      .rd_data(sq_rdata)
   );

   // Inverse map: letter to cell.
   pfc_ram #(
      .Width(5),
      .Depth(pfc_pkg::Cells)
   ) u_cell_of_letter (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_letter),
      .wr_data(fill_count_ff),
      .rd_addr(cell_rd_addr),
      .rd_data(cell_rdata)
   );

   // Result letter.
   assign out_idx                = cmd.out_second ? l2_ff : l1_ff;
   assign rsp_data.cipher_letter = {2'b00, out_idx} + pfc_pkg::AsciiA;
   assign rsp_data.last_of_pair  = cmd.out_second;

   `ASSERT_IMPLY(a_write_has_room, clock, reset, wr_en, room, "square write past the last cell")
   `ASSERT_IMPLY(a_key_square_full, clock, reset, key_ready_ff, &placed_ff, "key armed early")
   `ASSERT_IMPLY(a_emit_armed, clock, reset, stat.emit_start, key_ready_ff, "digraph before key")

endmodule

@@ sv/pfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfc_ctrl
// Sequencer for item acceptance, the key fill walk and digraph lookups.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pfc_pkg::pfc_stat_type stat,
   output pfc_pkg::pfc_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_CELL_A,
      S_CELL_B,
      S_CELL_C,
      S_SQ_A,
      S_SQ_B,
      S_SQ_C,
      S_EMIT1,
      S_EMIT2
   } state_type;

   state_type state_ff, state_in;

   // Handshake and command decode from the current state.
   always_comb begin
      cmd            = '0;
      req_stall      = state_ff != S_IDLE;
      rsp_valid      = (state_ff == S_EMIT1) || (state_ff == S_EMIT2);
      cmd.accept     = (state_ff == S_IDLE) && req_valid;
      cmd.fill_step  = state_ff == S_FILL;
      cmd.cell_rd_b  = state_ff == S_CELL_B;
      cmd.ca_load    = state_ff == S_CELL_B;
      cmd.cb_load    = state_ff == S_CELL_C;
      cmd.sq_rd_b    = state_ff == S_SQ_B;
      cmd.l1_load    = state_ff == S_SQ_B;
      cmd.l2_load    = state_ff == S_SQ_C;
      cmd.out_second = state_ff == S_EMIT2;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept && stat.fill_start) begin
               state_in = S_FILL;
            end else if (cmd.accept && stat.emit_start) begin
               state_in = S_CELL_A;
            end
         end
         S_FILL: begin
            if (stat.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_CELL_A: state_in = S_CELL_B;
         S_CELL_B: state_in = S_CELL_C;
         S_CELL_C: state_in = S_SQ_A;
         S_SQ_A:   state_in = S_SQ_B;
         S_SQ_B:   state_in = S_SQ_C;
         S_SQ_C:   state_in = S_EMIT1;
         S_EMIT1: begin
            if (!rsp_stall) begin
               state_in = S_EMIT2;
            end
         end
         S_EMIT2: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMPLY(a_no_accept_during_result, clock, reset, rsp_valid, req_stall, "input open while a result is pending")
   `ASSERT_NEXT(a_second_follows_first, clock, reset, rsp_valid && !rsp_stall && !cmd.out_second, rsp_valid && cmd.out_second, "second letter of a digraph missing")
   `ASSERT_NEXT(a_fill_returns_idle, clock, reset, cmd.fill_step && stat.fill_last, !req_stall, "fill walk did not release the input")

endmodule

@@ sv/playfair_digraph_cipher.sv @@
// Key-letter and text-letter transactions that close no digraph leave the input open.
// Key done is accepted and then runs a 25-step fill walk over the letters.
// A digraph presents its first letter after two reads of the cell RAM and two of the
// square RAM, each through its single registered port, and reopens the input after
// its second letter is taken. Reset clears the control state; the square RAMs are
// not cleared and are read only after the fill walk.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair encryption on a 5x5 key square with controller and datapath.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pfc_pkg::pfc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pfc_pkg::pfc_rsp_type rsp_data
);

   pfc_pkg::pfc_cmd_type  cmd;
   pfc_pkg::pfc_stat_type stat;

   // Sequencer.
   pfc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   // Storage and lookups.
   pfc_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .stat    (stat),
      .rsp_data(rsp_data)
   );

endmodule
